// ===== rtl/tidp_pkg.sv =====
// ----------------------------------------------------------------------------
// Tape image directory parser package
// Shared constants, result type and small decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tidp_pkg;

	localparam int unsigned SIG_LEN      = 20;
	localparam int unsigned COUNT_LO_POS = 34;
	localparam int unsigned COUNT_HI_POS = 35;
	localparam int unsigned MIN_IMAGE    = 63;
	localparam int unsigned SLOT_BASE    = 64;
	localparam int unsigned BLOCK_BYTES  = 254;

	localparam logic [4:0] OFF_IN_USE   = 5'd0;
	localparam logic [4:0] OFF_TYPE     = 5'd1;
	localparam logic [4:0] OFF_START_LO = 5'd2;
	localparam logic [4:0] OFF_START_HI = 5'd3;
	localparam logic [4:0] OFF_END_LO   = 5'd4;
	localparam logic [4:0] OFF_END_HI   = 5'd5;
	localparam logic [4:0] OFF_SIZE     = 5'd6;
	localparam logic [4:0] OFF_BLOCKS   = 5'd7;
	localparam logic [4:0] OFF_NAME_LEN = 5'd28;
	localparam logic [4:0] OFF_LAST     = 5'd31;

	localparam logic [7:0] PAD_SPACE   = 8'h20;
	localparam logic [7:0] PAD_SHIFTED = 8'hA0;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_SHORT   = 2'd1,
		STATUS_BAD_SIG = 2'd2
	} tidp_status_t;

	typedef struct packed {
		logic         has_entry;
		logic [15:0]  entry_number;
		logic [7:0]   file_type;
		logic [15:0]  payload_size;
		logic [31:0]  image_offset;
		logic [8:0]   size_blocks;
		logic [4:0]   name_length;
		logic [63:0]  name_head;
		logic [63:0]  name_tail;
		logic         is_final;
		tidp_status_t status;
	} tidp_result_t;

	// Expected header text, terminated by a zero byte.
	function automatic logic [7:0] sig_byte(input logic [4:0] idx);
		logic [7:0] b;
		unique case (idx)
			5'd0:  b = 8'h43;
			5'd1:  b = 8'h36;
			5'd2:  b = 8'h34;
			5'd3:  b = 8'h20;
			5'd4:  b = 8'h74;
			5'd5:  b = 8'h61;
			5'd6:  b = 8'h70;
			5'd7:  b = 8'h65;
			5'd8:  b = 8'h20;
			5'd9:  b = 8'h69;
			5'd10: b = 8'h6D;
			5'd11: b = 8'h61;
			5'd12: b = 8'h67;
			5'd13: b = 8'h65;
			5'd14: b = 8'h20;
			5'd15: b = 8'h66;
			5'd16: b = 8'h69;
			5'd17: b = 8'h6C;
			5'd18: b = 8'h65;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Rounds a size up to whole blocks. The quotient is estimated with a
	// reciprocal multiply (shift-add form) and fixed with one compare.
	function automatic logic [8:0] size_to_blocks(input logic [15:0] size);
		logic [16:0] x;
		logic [25:0] p;
		logic [8:0]  q;
		logic [16:0] qm;
		logic [16:0] r;
		x  = {1'b0, size} + 17'(BLOCK_BYTES - 1);
		p  = {1'b0, x, 8'h00} + {8'h00, x, 1'b0};
		q  = p[24:16];
		qm = {q, 8'h00} - {7'h00, q, 1'b0};
		r  = x - qm;
		if (r >= 17'(BLOCK_BYTES)) begin
			q = q + 9'd1;
		end
		return q;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tape_image_directory_parser.sv =====
// ----------------------------------------------------------------------------
// Tape image directory parser
// Parses a tape image byte stream and reports its directory entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one image byte per beat, with
//   is_last set on the final byte. Output channel (out_valid / out_stall)
//   carries one result beat for every in-use directory slot within the
//   declared count, while the header matches, and one closing beat for the
//   final byte with its status. Other bytes that are not last give no beat.
//   Each accepted byte passes through the input register and then the
//   result register, which presents its beat until it is taken; out_stall
//   can hold the byte in the input register between the two.
//   Throughput: one byte per cycle while the output is not stalled; the field
//   capture for a byte is a single pass between the input and result registers.
//   When out_stall holds a full result register, in_stall rises once the
//   input register is also occupied; nothing is dropped.
//   Reset empties both registers and restarts parsing at byte zero. The final
//   byte of an image also restarts parsing, so images may follow one another
//   directly.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_image_directory_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             has_entry,
	output logic [15:0]      entry_number,
	output logic [7:0]       file_type,
	output logic [15:0]      payload_size,
	output logic [31:0]      image_offset,
	output logic [8:0]       size_blocks,
	output logic [4:0]       name_length,
	output logic [63:0]      name_head,
	output logic [63:0]      name_tail,
	output logic             is_final,
	output logic [1:0]       status
);

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   last_s1;
	logic                   out_valid_q;
	tidp_pkg::tidp_result_t result_q;

	logic                   advance;
	logic                   step;
	logic                   produce;
	tidp_pkg::tidp_result_t result;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	tidp_slot_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.is_last   (last_s1),
		.produce   (produce),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= step && produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= is_last;
		end
		if (step && produce) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign has_entry    = result_q.has_entry;
	assign entry_number = result_q.entry_number;
	assign file_type    = result_q.file_type;
	assign payload_size = result_q.payload_size;
	assign image_offset = result_q.image_offset;
	assign size_blocks  = result_q.size_blocks;
	assign name_length  = result_q.name_length;
	assign name_head    = result_q.name_head;
	assign name_tail    = result_q.name_tail;
	assign is_final     = result_q.is_final;
	assign status       = result_q.status;

endmodule

`default_nettype wire

// ===== rtl/tidp_slot_capture.sv =====
// ----------------------------------------------------------------------------
// Tape image directory parser: field capture
// Tracks the byte position, checks the header, captures slot fields and
// forms the result for the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tidp_slot_capture (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  is_last,
	output logic                       produce,
	output tidp_pkg::tidp_result_t     result
);

	logic [31:0] pos_q;
	logic        sig_good_q;
	logic [15:0] count_q;
	logic        in_use_q;
	logic [7:0]  type_q;
	logic [15:0] start_q;
	logic [15:0] end_q;
	logic [15:0] size_q;
	logic [8:0]  blocks_q;
	logic [31:0] offset_q;
	logic [7:0]  name_q [16];
	logic [4:0]  len_q;

	logic        pos_in_sig;
	logic        in_slots;
	logic [31:0] rel;
	logic [4:0]  off;
	logic [26:0] slot_idx;
	logic        sig_next;
	logic        emit;
	logic [4:0]  trim_len;
	logic [4:0]  first_zero;
	logic [4:0]  name_len;
	logic [63:0] head;
	logic [63:0] tail;

	assign pos_in_sig = pos_q < 32'(tidp_pkg::SIG_LEN);
	assign in_slots   = pos_q >= 32'(tidp_pkg::SLOT_BASE);
	assign rel        = pos_q - 32'(tidp_pkg::SLOT_BASE);
	assign off        = rel[4:0];
	assign slot_idx   = rel[31:5];
	assign sig_next   = sig_good_q &&
		!(pos_in_sig && (data_byte != tidp_pkg::sig_byte(pos_q[4:0])));
	assign emit       = in_slots && (off == tidp_pkg::OFF_LAST) &&
		({11'h000, count_q} > slot_idx) && sig_good_q && in_use_q;
	assign produce    = emit || is_last;

	// Trailing pad bytes are trimmed, then the name stops at its first zero.
	always_comb begin
		trim_len   = 5'd0;
		first_zero = 5'd16;
		for (int k = 0; k < 16; k++) begin
			if (name_q[k] != tidp_pkg::PAD_SPACE && name_q[k] != tidp_pkg::PAD_SHIFTED) begin
				trim_len = 5'(k + 1);
			end
		end
		for (int k = 15; k >= 0; k--) begin
			if (name_q[k] == 8'h00) begin
				first_zero = 5'(k);
			end
		end
		name_len = (first_zero < trim_len) ? first_zero : trim_len;
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			head[8*k +: 8] = name_q[k];
			tail[8*k +: 8] = name_q[k + 8];
		end
	end

	always_comb begin
		result = '0;
		if (emit) begin
			result.has_entry    = 1'b1;
			result.entry_number = slot_idx[15:0];
			result.file_type    = type_q;
			result.payload_size = size_q;
			result.image_offset = offset_q;
			result.size_blocks  = blocks_q;
			result.name_length  = len_q;
			result.name_head    = head;
			result.name_tail    = tail;
		end
		result.is_final = is_last;
		result.status   = tidp_pkg::STATUS_OK;
		if (is_last) begin
			if (pos_q < 32'(tidp_pkg::MIN_IMAGE)) begin
				result.status = tidp_pkg::STATUS_SHORT;
			end else if (!sig_next) begin
				result.status = tidp_pkg::STATUS_BAD_SIG;
			end
		end
	end

	// Control state: position and header check. The final byte restarts both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sig_good_q <= 1'b1;
		end else if (step) begin
			if (is_last) begin
				pos_q      <= '0;
				sig_good_q <= 1'b1;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + 32'd1;
				end
				sig_good_q <= sig_next;
			end
		end
	end

	// Field capture. Every field is written, in the header or inside a slot, before it
	// is read, so these registers need no reset. Size, block count and name length are
	// worked out on spare slot bytes ahead of the slot's last byte.
	always_ff @(posedge clk) begin
		if (step) begin
			if (pos_q == 32'(tidp_pkg::COUNT_LO_POS)) begin
				count_q[7:0] <= data_byte;
			end
			if (pos_q == 32'(tidp_pkg::COUNT_HI_POS)) begin
				count_q[15:8] <= data_byte;
			end
			if (in_slots) begin
				case (off) inside
					tidp_pkg::OFF_IN_USE:   in_use_q      <= (data_byte != 8'h00);
					tidp_pkg::OFF_TYPE:     type_q        <= data_byte;
					tidp_pkg::OFF_START_LO: start_q[7:0]  <= data_byte;
					tidp_pkg::OFF_START_HI: start_q[15:8] <= data_byte;
					tidp_pkg::OFF_END_LO:   end_q[7:0]    <= data_byte;
					tidp_pkg::OFF_END_HI:   end_q[15:8]   <= data_byte;
					tidp_pkg::OFF_SIZE:     size_q <= (end_q > start_q) ? (end_q - start_q) : 16'h0000;
					tidp_pkg::OFF_BLOCKS:   blocks_q <= tidp_pkg::size_to_blocks(size_q);
					[5'd8:5'd11]:           offset_q[8*off[1:0] +: 8] <= data_byte;
					[5'd12:5'd27]:          name_q[off[3:0] - 4'd12] <= data_byte;
					tidp_pkg::OFF_NAME_LEN: len_q <= name_len;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire
